>>> hdl/dtwcm_pkg.sv
// package for the banded dtw cost grid
// widths, default sizes and configuration register codes; no dependencies
package dtwcm_pkg;

  localparam int DIST_WIDTH     = 32;
  localparam int ROW_WIDTH      = 16;
  localparam int NCOLS_WIDTH    = 11;
  localparam int BANDW_WIDTH    = 10;
  localparam int MAX_COLS_DEF   = 1024;
  localparam int COST_WIDTH_DEF = 48;
  localparam int APB_AW         = 4;
  localparam int APB_DW         = 32;

  typedef enum logic [1:0] {
    REG_N_ROWS      = 2'd0,
    REG_N_COLS      = 2'd1,
    REG_BAND_ENABLE = 2'd2,
    REG_BAND_WIDTH  = 2'd3
  } reg_idx_e;

endpackage

>>> hdl/dtwcm_dist_if.sv
// request channel carrying one local distance per grid cell
// depends on dtwcm_pkg
interface dtwcm_dist_if
  import dtwcm_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [DIST_WIDTH-1:0] dist_req;

  modport source (output valid, output dist_req, input ready);
  modport sink   (input valid, input dist_req, output ready);
endinterface

>>> hdl/dtwcm_cost_if.sv
// result channel carrying the accumulated cost of one grid cell
// depends on dtwcm_pkg
interface dtwcm_cost_if
  import dtwcm_pkg::*;
#(
  parameter int COST_WIDTH = COST_WIDTH_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [COST_WIDTH-1:0] cost;
  logic                  in_band;
  logic                  row_end;
  logic                  last_cell;

  modport source (output valid, output cost, output in_band, output row_end,
                  output last_cell, input ready);
  modport sink   (input valid, input cost, input in_band, input row_end,
                  input last_cell, output ready);
endinterface

>>> hdl/dtw_cost_matrix_banded.sv
// banded dynamic time warping cost grid, top level
// depends on dtwcm_pkg, dtwcm_dist_if, dtwcm_cost_if
//
// usage:
//   dist_i takes the local distances of an n_rows x n_cols grid in row-major
//   order, one request per cell. cost_o returns one result per request, in
//   order: the accumulated cost (all ones is infinity), the band flag, the
//   row end flag and the last cell flag. after the last cell the next request
//   starts a new grid.
//   configuration is written over the apb port while the block is idle:
//   n_rows at 0x0, n_cols at 0x4, band_enable at 0x8, band_width at 0xc.
//   each request is held in the compute stage, then in the output register.
//   throughput: one cell per cycle while cost_o takes results; the previous
//   row is in a one-port-read, one-port-write memory of MAX_COLS entries; the
//   left neighbour feeds back via one add and compare in the compute stage.
//   reset: indices go to zero, neighbour costs to infinity, registers to
//   n_rows 1, n_cols 1, band off, band width 0; the row memory is not cleared.
//   stall: a stalled result holds in the output register; one more request is
//   taken into the compute stage, then dist_i.ready drops until cost_o moves.
module dtw_cost_matrix_banded
  import dtwcm_pkg::*;
#(
  parameter int MAX_COLS   = MAX_COLS_DEF,
  parameter int COST_WIDTH = COST_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  dtwcm_dist_if.sink        dist_i,
  dtwcm_cost_if.source      cost_o
);

  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CNT_W = ((CW > NCOLS_WIDTH) ? CW : NCOLS_WIDTH) + 1;
  localparam int DW    = (ROW_WIDTH > CW) ? ROW_WIDTH : CW;
  localparam logic [COST_WIDTH-1:0] COST_INF = {COST_WIDTH{1'b1}};

  // configuration registers
  logic [ROW_WIDTH-1:0]   n_rows_q;
  logic [NCOLS_WIDTH-1:0] n_cols_q;
  logic                   band_en_q;
  logic [BANDW_WIDTH-1:0] band_w_q;
  logic                   cfg_wr;
  reg_idx_e               cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_rows_q  <= ROW_WIDTH'(1);
      n_cols_q  <= NCOLS_WIDTH'(1);
      band_en_q <= 1'b0;
      band_w_q  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_N_ROWS:      n_rows_q  <= pwdata[ROW_WIDTH-1:0];
        REG_N_COLS:      n_cols_q  <= pwdata[NCOLS_WIDTH-1:0];
        REG_BAND_ENABLE: band_en_q <= pwdata[0];
        REG_BAND_WIDTH:  band_w_q  <= pwdata[BANDW_WIDTH-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_N_ROWS:      prdata = APB_DW'(n_rows_q);
      REG_N_COLS:      prdata = APB_DW'(n_cols_q);
      REG_BAND_ENABLE: prdata = APB_DW'(band_en_q);
      REG_BAND_WIDTH:  prdata = APB_DW'(band_w_q);
    endcase
  end

  // handshake
  logic a_valid_q, a_adv, o_valid_q, o_take, acc;

  assign o_take       = o_valid_q && cost_o.ready;
  assign a_adv        = a_valid_q && (!o_valid_q || o_take);
  assign dist_i.ready = !a_valid_q || a_adv;
  assign acc          = dist_i.valid && dist_i.ready;

  // grid position at request time
  logic [ROW_WIDTH-1:0] row_q;
  logic [CW-1:0]        col_q;
  logic [CNT_W-1:0]     cols_eff, col_inc;
  logic [ROW_WIDTH:0]   rows_eff, row_inc;
  logic [DW-1:0]        diff;
  logic                 inb, rend, lend;

  always_comb begin
    cols_eff = CNT_W'(n_cols_q);
    if (cols_eff == '0) begin
      cols_eff = CNT_W'(1);
    end else if (cols_eff > CNT_W'(MAX_COLS)) begin
      cols_eff = CNT_W'(MAX_COLS);
    end
    rows_eff = (n_rows_q == '0) ? (ROW_WIDTH+1)'(1) : {1'b0, n_rows_q};
    col_inc  = CNT_W'(col_q) + CNT_W'(1);
    row_inc  = {1'b0, row_q} + (ROW_WIDTH+1)'(1);
    rend     = col_inc >= cols_eff;
    lend     = rend && (row_inc >= rows_eff);
    diff     = (DW'(row_q) > DW'(col_q)) ? DW'(row_q) - DW'(col_q)
                                         : DW'(col_q) - DW'(row_q);
    inb      = !band_en_q || (diff <= DW'(band_w_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (acc) begin
      if (rend) begin
        col_q <= '0;
        row_q <= lend ? '0 : row_inc[ROW_WIDTH-1:0];
      end else begin
        col_q <= col_inc[CW-1:0];
      end
    end
  end

  // compute stage
  logic [DIST_WIDTH-1:0] a_dist_q;
  logic [CW-1:0]         a_col_q;
  logic                  a_row0_q, a_col0_q, a_inb_q, a_rend_q, a_lend_q;
  logic [COST_WIDTH-1:0] left_q, diag_q;
  logic [COST_WIDTH-1:0] rd_q, fwd_cost_q;
  logic                  fwd_q;
  logic [COST_WIDTH-1:0] prev_row_q [MAX_COLS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (acc) begin
      a_valid_q <= 1'b1;
    end else if (a_adv) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      a_dist_q <= dist_i.dist_req;
      a_col_q  <= col_q;
      a_row0_q <= (row_q == '0);
      a_col0_q <= (col_q == '0);
      a_inb_q  <= inb;
      a_rend_q <= rend;
      a_lend_q <= lend;
    end
  end

  logic [COST_WIDTH-1:0] up, m_left, m_diag, best, cost;
  logic [COST_WIDTH:0]   sum;

  always_comb begin
    up     = a_row0_q ? COST_INF : (fwd_q ? fwd_cost_q : rd_q);
    m_left = a_col0_q ? COST_INF : left_q;
    m_diag = (a_row0_q || a_col0_q) ? COST_INF : diag_q;
    best   = (up < m_left) ? up : m_left;
    best   = (m_diag < best) ? m_diag : best;
    sum    = {1'b0, best} + (COST_WIDTH+1)'(a_dist_q);
    if (!a_inb_q) begin
      cost = COST_INF;
    end else if (a_row0_q && a_col0_q) begin
      cost = COST_WIDTH'(a_dist_q);
    end else if (best == COST_INF) begin
      cost = COST_INF;
    end else if (sum >= {1'b0, COST_INF}) begin
      cost = COST_INF - COST_WIDTH'(1);
    end else begin
      cost = sum[COST_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= COST_INF;
      diag_q <= COST_INF;
    end else if (a_adv) begin
      left_q <= a_rend_q ? COST_INF : cost;
      diag_q <= a_rend_q ? COST_INF : up;
    end
  end

  // previous row memory, with forwarding of a write that lands with the read
  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      prev_row_q[a_col_q] <= cost;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      rd_q       <= prev_row_q[col_q];
      fwd_cost_q <= cost;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (acc) begin
      fwd_q <= a_adv && (a_col_q == col_q);
    end
  end

  // output register
  logic [COST_WIDTH-1:0] o_cost_q;
  logic                  o_inb_q, o_rend_q, o_lend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (a_adv) begin
      o_valid_q <= 1'b1;
    end else if (o_take) begin
      o_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      o_cost_q <= cost;
      o_inb_q  <= a_inb_q;
      o_rend_q <= a_rend_q;
      o_lend_q <= a_lend_q;
    end
  end

  assign cost_o.valid     = o_valid_q;
  assign cost_o.cost      = o_cost_q;
  assign cost_o.in_band   = o_inb_q;
  assign cost_o.row_end   = o_rend_q;
  assign cost_o.last_cell = o_lend_q;

endmodule
